// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pair force block.
// Expects clk and arst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// condition implies expression in the next cycle
`define ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEXT(label, cond, expr)
`endif
`endif

// File: hw/rtl/ljpf_pkg.sv
// Package of the Lennard-Jones pair force block: widths, constants, types.
// No dependencies.
`default_nettype none
package ljpf_pkg;

	localparam int IDX_W        = 12;
	localparam int POS_W        = 32;
	localparam int FORCE_W      = 48;
	localparam int CHAIN_W      = 13;
	localparam int COEF_W       = 32;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int MAX_MONOMERS = 4096;

	localparam logic [CHAIN_W-1:0] CHAIN_LEN_RST  = 13'd4096;
	localparam logic [COEF_W-1:0]  REP_COEF_RST   = 32'd3145728;
	localparam logic [COEF_W-1:0]  ATT_COEF_RST   = 32'd1572864;

	// saturation limits
	localparam logic [63:0] CAP62     = 64'h4000_0000_0000_0000;
	localparam logic [63:0] FMAX_Q24  = 64'd300 << 24;
	localparam logic [63:0] FORCE_CAP = (64'd1 << 47) - 64'd1;
	localparam logic [63:0] RECIP_SMALL_MAX = 64'd4;

	// reciprocal: remainder after the three leading dividend bits, one quotient bit per stage
	localparam int DIV_STAGES = 62;
	localparam logic [63:0] REM_INIT = 64'd4;

	// pipeline stage numbers
	localparam int S_R2   = 4;
	localparam int S_INV2 = S_R2 + DIV_STAGES;
	localparam int S_INV4 = S_INV2 + 2;
	localparam int S_INV6 = S_INV4 + 2;
	localparam int S_INV8 = S_INV6 + 2;
	localparam int S_G    = S_INV8 + 1;
	localparam int S_FMAG = S_G + 2;
	localparam int S_FMUL = S_FMAG + 2;
	localparam int S_OUT  = S_FMUL + 1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CHAIN_LENGTH = 2'd0,
		REG_FIXED_ENDS   = 2'd1,
		REG_REP_COEF     = 2'd2,
		REG_ATT_COEF     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0]     first_index;
		logic [IDX_W-1:0]     second_index;
		logic                 ok;
		logic                 keep2;
		logic [2:0]           neg;
		logic [2:0][POS_W-1:0] dm;
	} item_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		logic                      apply_first;
		logic                      apply_second;
		logic [IDX_W-1:0]          target_first;
		logic [IDX_W-1:0]          target_second;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/ljpf_pair_if.sv
// Request channel carrying one neighbour pair with positions.
// Depends on ljpf_pkg.
`default_nettype none
interface ljpf_pair_if import ljpf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         first_index;
	logic [IDX_W-1:0]         second_index;
	logic signed [POS_W-1:0]  first_x;
	logic signed [POS_W-1:0]  first_y;
	logic signed [POS_W-1:0]  first_z;
	logic signed [POS_W-1:0]  second_x;
	logic signed [POS_W-1:0]  second_y;
	logic signed [POS_W-1:0]  second_z;

	modport source (output valid, first_index, second_index, first_x, first_y, first_z,
		second_x, second_y, second_z, input ready);
	modport sink (input valid, first_index, second_index, first_x, first_y, first_z,
		second_x, second_y, second_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ljpf_force_if.sv
// Result channel carrying one pair force and its apply flags.
// Depends on ljpf_pkg.
`default_nettype none
interface ljpf_force_if import ljpf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FORCE_W-1:0] force_x;
	logic signed [FORCE_W-1:0] force_y;
	logic signed [FORCE_W-1:0] force_z;
	logic                      apply_first;
	logic                      apply_second;
	logic [IDX_W-1:0]          target_first;
	logic [IDX_W-1:0]          target_second;

	modport source (output valid, force_x, force_y, force_z, apply_first, apply_second,
		target_first, target_second, input ready);
	modport sink (input valid, force_x, force_y, force_z, apply_first, apply_second,
		target_first, target_second, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ljpf_recip.sv
// Pipelined restoring divider giving floor(2^64 / r2), capped at 2^62.
// Depends on ljpf_pkg; one quotient bit per stage.
`default_nettype none
module ljpf_recip import ljpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] r2,
	output logic [63:0]      inv2
);

	logic [63:0]           rem_s  [DIV_STAGES];
	logic [63:0]           div_s  [DIV_STAGES];
	logic [DIV_STAGES-1:0] quo_s  [DIV_STAGES];
	logic                  tiny_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [63:0]           rem_p;
		logic [63:0]           div_p;
		logic [DIV_STAGES-1:0] quo_p;
		logic                  tiny_p;
		logic [64:0]           t;
		logic [64:0]           diff;
		logic                  ge;

		// first stage starts from the leading dividend bits
		if (k == 0) begin : g_head
			assign rem_p  = REM_INIT;
			assign div_p  = r2;
			assign quo_p  = '0;
			assign tiny_p = (r2 <= RECIP_SMALL_MAX);
		end else begin : g_tail
			assign rem_p  = rem_s[k-1];
			assign div_p  = div_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign tiny_p = tiny_s[k-1];
		end

		// shift in a zero dividend bit, trial subtract
		assign t    = {rem_p, 1'b0};
		assign diff = t - {1'b0, div_p};
		assign ge   = (t >= {1'b0, div_p});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[63:0] : t[63:0];
				div_s[k]  <= div_p;
				quo_s[k]  <= {quo_p[DIV_STAGES-2:0], ge};
				tiny_s[k] <= tiny_p;
			end
		end
	end

	// small distances saturate
	assign inv2 = tiny_s[DIV_STAGES-1] ? CAP62 : 64'(quo_s[DIV_STAGES-1]);

endmodule
`default_nettype wire

// File: hw/rtl/ljpf_mulsat.sv
// Two-stage 64x64 multiply, right shift and saturate to a cap.
// Depends on ljpf_pkg; four 32x32 partial products in the first stage.
`default_nettype none
module ljpf_mulsat import ljpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic [5:0]  sh,
	input  wire logic [63:0] cap,
	output logic [63:0]      y
);

	logic [63:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic [127:0] prod;
	logic [127:0] shifted;
	logic [63:0]  y_d;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0])  * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0])  * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	// combine, scale and saturate
	always_comb begin
		prod = {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
			+ {p11_s1, 64'd0};
		shifted = prod >> sh;
		y_d = ((|shifted[127:64]) || (shifted[63:0] > cap)) ? cap : shifted[63:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= y_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/lennard_jones_pair_force.sv
// Lennard-Jones 12-6 pair force pipeline, top level.
// Depends on ljpf_pkg, ljpf_pair_if, ljpf_force_if, ljpf_recip, ljpf_mulsat.
//
// Usage:
//   pairs  : request channel, one neighbour pair (indices and positions) per
//            request, taken when valid and ready are both high.
//   forces : result channel, exactly one result per request, in order.
//   cfg_*  : register writes (chain length, fixed ends, two coefficients),
//            applied at any edge with cfg_wr_en high; write only while idle.
// Path: front stages, reciprocal divider, multiply levels, res_s78, out_q.
// Throughput: one pair per cycle while pairs.ready is high; depth is set by
// the 62-stage reciprocal divider, then five pipelined 64x64 multiply levels.
// Stall: the whole pipeline advances together; an output register plus one
// skid register catch the item in flight, and pairs.ready drops while the
// skid register is full. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits and loads the register defaults
// (chain length 4096, fixed ends off, coefficients 48.0 and 24.0).
`default_nettype none
`include "assert_macros.svh"
module lennard_jones_pair_force import ljpf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	ljpf_pair_if.sink                  pairs,
	ljpf_force_if.source               forces
);

	logic [CHAIN_W-1:0] chain_len_q;
	logic               fixed_ends_q;
	logic [COEF_W-1:0]  rep_coef_q;
	logic [COEF_W-1:0]  att_coef_q;

	logic en;
	logic vld_s [1:S_OUT];

	logic [CHAIN_W-1:0]    n_eff, i_ext, j_ext;
	logic                  idx_ok, keep2;
	logic signed [POS_W:0] d_in [3];
	logic [POS_W-1:0]      pa [3];
	logic [POS_W-1:0]      pb [3];

	logic signed [POS_W:0] d_s1 [3];
	logic [IDX_W-1:0]      i_s1, j_s1;
	logic                  ok_s1, keep2_s1;

	item_t       item_s [2:S_FMUL];
	item_t       item_d;
	logic [63:0] sq_s3 [3];
	logic [65:0] r2_sum;
	logic [63:0] r2_s4;

	logic [63:0] inv2_div, inv4, inv6, inv8, rep_p, fmag;
	logic [63:0] inv2_s [S_INV2+1:S_INV6];
	logic [64:0] g_val;
	logic [63:0] gmag_s73, inv8_s73;
	logic        fneg_s [S_G:S_FMUL];
	logic [63:0] fm [3];

	result_t res_d, res_s78, out_q, skid_q;
	logic    out_v_q, skid_v_q, arrive;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_len_q  <= CHAIN_LEN_RST;
			fixed_ends_q <= 1'b0;
			rep_coef_q   <= REP_COEF_RST;
			att_coef_q   <= ATT_COEF_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_CHAIN_LENGTH: chain_len_q  <= cfg_wdata[CHAIN_W-1:0];
				REG_FIXED_ENDS:   fixed_ends_q <= cfg_wdata[0];
				REG_REP_COEF:     rep_coef_q   <= cfg_wdata[COEF_W-1:0];
				REG_ATT_COEF:     att_coef_q   <= cfg_wdata[COEF_W-1:0];
				default:          ;
			endcase
		end
	end

	// global advance while the skid register is free
	assign en          = !skid_v_q;
	assign pairs.ready = en;

	// index checks and displacement
	always_comb begin
		n_eff = (chain_len_q > CHAIN_W'(MAX_MONOMERS)) ? CHAIN_W'(MAX_MONOMERS) : chain_len_q;
		i_ext = {1'b0, pairs.first_index};
		j_ext = {1'b0, pairs.second_index};
		idx_ok = (n_eff >= CHAIN_W'(2)) && (i_ext != '0) && ((i_ext + CHAIN_W'(1)) < n_eff)
			&& (j_ext > i_ext) && (j_ext < n_eff);
		keep2 = !(fixed_ends_q && (j_ext == (n_eff - CHAIN_W'(1))));
		pa[0] = pairs.first_x;  pb[0] = pairs.second_x;
		pa[1] = pairs.first_y;  pb[1] = pairs.second_y;
		pa[2] = pairs.first_z;  pb[2] = pairs.second_z;
		for (int k = 0; k < 3; k++) begin
			d_in[k] = $signed({pa[k][POS_W-1], pa[k]}) - $signed({pb[k][POS_W-1], pb[k]});
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_OUT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= pairs.valid;
			for (int k = 2; k <= S_OUT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// magnitude, sign and zero-distance check
	always_comb begin
		item_d.first_index  = i_s1;
		item_d.second_index = j_s1;
		item_d.keep2        = keep2_s1;
		for (int k = 0; k < 3; k++) begin
			item_d.neg[k] = d_s1[k][POS_W];
			item_d.dm[k]  = d_s1[k][POS_W] ? POS_W'(-d_s1[k]) : d_s1[k][POS_W-1:0];
		end
		item_d.ok = ok_s1 && ((item_d.dm[0] | item_d.dm[1] | item_d.dm[2]) != '0);
	end

	// saturating sum of squares
	always_comb begin
		r2_sum = 66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2]);
	end

	// front stages and payload delay line
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1     <= d_in;
			i_s1     <= pairs.first_index;
			j_s1     <= pairs.second_index;
			ok_s1    <= idx_ok;
			keep2_s1 <= keep2;
			item_s[2] <= item_d;
			for (int k = 0; k < 3; k++)
				sq_s3[k] <= 64'(item_s[2].dm[k]) * 64'(item_s[2].dm[k]);
			r2_s4 <= (|r2_sum[65:64]) ? '1 : r2_sum[63:0];
			for (int k = 3; k <= S_FMUL; k++) item_s[k] <= item_s[k-1];
		end
	end

	ljpf_recip u_recip (
		.clk  (clk),
		.en   (en),
		.r2   (r2_s4),
		.inv2 (inv2_div)
	);

	// inv2 kept alongside the power chain
	always_ff @(posedge clk) begin
		if (en) begin
			inv2_s[S_INV2+1] <= inv2_div;
			for (int k = S_INV2 + 2; k <= S_INV6; k++) inv2_s[k] <= inv2_s[k-1];
		end
	end

	ljpf_mulsat u_inv4 (.clk(clk), .en(en), .a(inv2_div), .b(inv2_div), .sh(6'd24),
		.cap(CAP62), .y(inv4));
	ljpf_mulsat u_inv6 (.clk(clk), .en(en), .a(inv4), .b(inv2_s[S_INV4]), .sh(6'd24),
		.cap(CAP62), .y(inv6));
	ljpf_mulsat u_inv8 (.clk(clk), .en(en), .a(inv6), .b(inv2_s[S_INV6]), .sh(6'd24),
		.cap(CAP62), .y(inv8));
	ljpf_mulsat u_rep (.clk(clk), .en(en), .a({32'd0, rep_coef_q}), .b(inv6), .sh(6'd16),
		.cap(CAP62), .y(rep_p));

	// repulsive minus attractive term
	assign g_val = {1'b0, rep_p} - {25'd0, att_coef_q, 8'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			gmag_s73  <= g_val[64] ? 64'(-g_val) : g_val[63:0];
			inv8_s73  <= inv8;
			fneg_s[S_G] <= g_val[64];
			for (int k = S_G + 1; k <= S_FMUL; k++) fneg_s[k] <= fneg_s[k-1];
		end
	end

	ljpf_mulsat u_fmag (.clk(clk), .en(en), .a(gmag_s73), .b(inv8_s73), .sh(6'd24),
		.cap(FMAX_Q24), .y(fmag));

	for (genvar k = 0; k < 3; k++) begin : g_axis
		ljpf_mulsat u_fax (.clk(clk), .en(en), .a(fmag), .b({32'd0, item_s[S_FMAG].dm[k]}),
			.sh(6'd24), .cap(FORCE_CAP), .y(fm[k]));
	end

	// sign, skip gating and flags
	always_comb begin
		logic [FORCE_W-1:0] f [3];
		for (int k = 0; k < 3; k++) begin
			f[k] = (fneg_s[S_FMUL] != item_s[S_FMUL].neg[k]) ? FORCE_W'(-fm[k])
				: fm[k][FORCE_W-1:0];
			if (!item_s[S_FMUL].ok) f[k] = '0;
		end
		res_d.force_x       = f[0];
		res_d.force_y       = f[1];
		res_d.force_z       = f[2];
		res_d.apply_first   = item_s[S_FMUL].ok;
		res_d.apply_second  = item_s[S_FMUL].ok && item_s[S_FMUL].keep2;
		res_d.target_first  = item_s[S_FMUL].first_index;
		res_d.target_second = item_s[S_FMUL].second_index;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s78 <= res_d;
		end
	end

	// output register with skid stage
	assign arrive = en && vld_s[S_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || forces.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= arrive;
			end
		end else if (arrive) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || forces.ready) begin
			out_q <= skid_v_q ? skid_q : res_s78;
		end else if (arrive) begin
			skid_q <= res_s78;
		end
	end

	assign forces.valid         = out_v_q;
	assign forces.force_x       = out_q.force_x;
	assign forces.force_y       = out_q.force_y;
	assign forces.force_z       = out_q.force_z;
	assign forces.apply_first   = out_q.apply_first;
	assign forces.apply_second  = out_q.apply_second;
	assign forces.target_first  = out_q.target_first;
	assign forces.target_second = out_q.target_second;

	// skid register only fills behind a full output register
	`ASSERT_ALWAYS(a_skid_behind_out, !skid_v_q || out_v_q)
	// skid fills only when the receiver stalls
	`ASSERT_NEXT(a_skid_on_stall, !skid_v_q && !(out_v_q && !forces.ready), !skid_v_q)
	// neighbour flag never without the first-monomer flag
	`ASSERT_ALWAYS(a_apply_order, !out_v_q || !out_q.apply_second || out_q.apply_first)
	// skipped pairs carry no force
	`ASSERT_ALWAYS(a_skip_zero, !out_v_q || out_q.apply_first || ((out_q.force_x == '0)
		&& (out_q.force_y == '0) && (out_q.force_z == '0)))

endmodule
`default_nettype wire
